[sv/tsz_pkg.sv]
// Shared types for the zero-sum triplet finder.
package tsz_pkg;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SORT_RD_KEY,
    ST_SORT_WAIT_KEY,
    ST_SORT_RD_PREV,
    ST_SORT_CMP,
    ST_SCAN_ANCHOR,
    ST_SCAN_RD_A,
    ST_SCAN_RD_AP,
    ST_SCAN_CHK_A,
    ST_SCAN_RD_LO,
    ST_SCAN_RD_HI,
    ST_SCAN_SUM,
    ST_SKIP_LO_RD,
    ST_SKIP_LO_CMP,
    ST_SKIP_HI_RD,
    ST_SKIP_HI_CMP,
    ST_EMIT,
    ST_SUMMARY
  } state_t;

  typedef struct packed {
    logic signed [31:0] first_value;
    logic signed [31:0] middle_value;
    logic signed [31:0] third_value;
    logic               is_summary;
    logic               found_any;
    logic               triplets_dropped;
    logic               inputs_dropped;
  } result_t;

endpackage

[sv/three_sum_zero_triplets_top.sv]
// Top level: load, insertion sort in memory, two-pointer three-sum scan.
//
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_stall   | value, last
//  out     | out | out_valid/out_stall | triplet fields, flags, end_of_run
//
// Non-last items are taken back to back while loading. The last item starts
// an insertion sort in the store (one write port, one registered read port),
// then the two-pointer scan. Reset is synchronous; the store needs no
// clearing. A full, stalled output holds the sequencer when it has a result
// to load; input is stalled from the last item until the summary is loaded.
module three_sum_zero_triplets_top #(
  parameter int MAX_ITEMS    = 64,
  parameter int MAX_TRIPLETS = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] first_value,
  output logic signed [31:0] middle_value,
  output logic signed [31:0] third_value,
  output logic               is_summary,
  output logic               found_any,
  output logic               triplets_dropped,
  output logic               inputs_dropped,
  output logic               end_of_run
);
  import tsz_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int TW = $clog2(MAX_TRIPLETS + 1);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic ovf, ovf_next, found, found_next, tdrop, tdrop_next;
  logic [TW-1:0] emitted, emitted_next;
  logic [CW-1:0] i, i_next, j, j_next, lo, lo_next, hi, hi_next;
  logic signed [31:0] key, key_next, va, va_next, vlo, vlo_next, vhi, vhi_next;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [31:0] wdata, rdata;
  logic out_load, out_full;
  result_t res, res_out;
  logic signed [33:0] sum;

  tsz_store #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata);

  tsz_out u_out (.clk, .rst, .load(out_load), .din(res), .full(out_full),
    .stall(out_stall), .dout(res_out));

  assign out_valid        = out_full;
  assign first_value      = res_out.first_value;
  assign middle_value     = res_out.middle_value;
  assign third_value      = res_out.third_value;
  assign is_summary       = res_out.is_summary;
  assign found_any        = res_out.found_any;
  assign triplets_dropped = res_out.triplets_dropped;
  assign inputs_dropped   = res_out.inputs_dropped;
  assign end_of_run       = res_out.is_summary;
  assign in_stall         = (state != ST_LOAD);

  assign sum = 34'(va) + 34'(vlo) + 34'(vhi);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      ovf     <= 1'b0;
      found   <= 1'b0;
      tdrop   <= 1'b0;
      emitted <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      ovf     <= ovf_next;
      found   <= found_next;
      tdrop   <= tdrop_next;
      emitted <= emitted_next;
    end
    i   <= i_next;
    j   <= j_next;
    lo  <= lo_next;
    hi  <= hi_next;
    key <= key_next;
    va  <= va_next;
    vlo <= vlo_next;
    vhi <= vhi_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    ovf_next     = ovf;
    found_next   = found;
    tdrop_next   = tdrop;
    emitted_next = emitted;
    i_next = i; j_next = j; lo_next = lo; hi_next = hi;
    key_next = key; va_next = va; vlo_next = vlo; vhi_next = vhi;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    out_load = 1'b0;
    res = '0;
    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          if (count < CW'(MAX_ITEMS)) begin
            we = 1'b1; waddr = count[AW-1:0]; wdata = value;
            count_next = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          if (last) begin
            i_next = CW'(1);
            state_next = ST_SORT_RD_KEY;
          end
        end
      end
      ST_SORT_RD_KEY: begin
        if (i >= count) begin
          i_next = '0;
          state_next = ST_SCAN_ANCHOR;
        end else begin
          raddr = i[AW-1:0];
          j_next = i;
          state_next = ST_SORT_WAIT_KEY;
        end
      end
      ST_SORT_WAIT_KEY: begin
        key_next = rdata;
        state_next = ST_SORT_RD_PREV;
      end
      ST_SORT_RD_PREV: begin
        if (j == '0) begin
          we = 1'b1; waddr = '0; wdata = key;
          i_next = i + 1'b1;
          state_next = ST_SORT_RD_KEY;
        end else begin
          raddr = AW'(j - 1'b1);
          state_next = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        we = 1'b1; waddr = j[AW-1:0];
        if (rdata > key) begin
          wdata = rdata;
          j_next = j - 1'b1;
          state_next = ST_SORT_RD_PREV;
        end else begin
          wdata = key;
          i_next = i + 1'b1;
          state_next = ST_SORT_RD_KEY;
        end
      end
      ST_SCAN_ANCHOR: begin
        if ({1'b0, i} + 2'd2 >= {1'b0, count}) begin
          state_next = ST_SUMMARY;
        end else begin
          raddr = i[AW-1:0];
          state_next = ST_SCAN_RD_A;
        end
      end
      ST_SCAN_RD_A: begin
        va_next = rdata;
        if (i == '0) begin
          lo_next = i + 1'b1;
          hi_next = count - 1'b1;
          state_next = ST_SCAN_RD_LO;
        end else begin
          raddr = AW'(i - 1'b1);
          state_next = ST_SCAN_RD_AP;
        end
      end
      ST_SCAN_RD_AP: begin
        // keep the previous anchor's address so rdata still holds it next cycle
        raddr = AW'(i - 1'b1);
        state_next = ST_SCAN_CHK_A;
      end
      ST_SCAN_CHK_A: begin
        if (rdata == va) begin
          i_next = i + 1'b1;
          state_next = ST_SCAN_ANCHOR;
        end else begin
          lo_next = i + 1'b1;
          hi_next = count - 1'b1;
          state_next = ST_SCAN_RD_LO;
        end
      end
      ST_SCAN_RD_LO: begin
        if (lo >= hi) begin
          i_next = i + 1'b1;
          state_next = ST_SCAN_ANCHOR;
        end else begin
          raddr = lo[AW-1:0];
          state_next = ST_SCAN_RD_HI;
        end
      end
      ST_SCAN_RD_HI: begin
        vlo_next = rdata;
        raddr = hi[AW-1:0];
        state_next = ST_SCAN_SUM;
      end
      ST_SCAN_SUM: begin
        vhi_next = rdata;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sum == '0) begin
          found_next = 1'b1;
          if (emitted < TW'(MAX_TRIPLETS)) begin
            if (!out_full || !out_stall) begin
              out_load = 1'b1;
              res.first_value  = va;
              res.middle_value = vlo;
              res.third_value  = vhi;
              emitted_next = emitted + 1'b1;
              state_next = ST_SKIP_LO_RD;
            end else begin
              found_next = found;
            end
          end else begin
            tdrop_next = 1'b1;
            state_next = ST_SKIP_LO_RD;
          end
        end else if (sum < 0) begin
          lo_next = lo + 1'b1;
          state_next = ST_SCAN_RD_LO;
        end else begin
          hi_next = hi - 1'b1;
          state_next = ST_SCAN_RD_LO;
        end
      end
      ST_SKIP_LO_RD: begin
        if (lo < hi) begin
          raddr = AW'(lo + 1'b1);
          state_next = ST_SKIP_LO_CMP;
        end else begin
          state_next = ST_SKIP_HI_RD;
        end
      end
      ST_SKIP_LO_CMP: begin
        if (rdata == vlo) begin
          lo_next = lo + 1'b1;
          state_next = ST_SKIP_LO_RD;
        end else begin
          state_next = ST_SKIP_HI_RD;
        end
      end
      ST_SKIP_HI_RD: begin
        if (lo < hi) begin
          raddr = AW'(hi - 1'b1);
          state_next = ST_SKIP_HI_CMP;
        end else begin
          lo_next = lo + 1'b1;
          hi_next = hi - 1'b1;
          state_next = ST_SCAN_RD_LO;
        end
      end
      ST_SKIP_HI_CMP: begin
        if (rdata == vhi) begin
          hi_next = hi - 1'b1;
          state_next = ST_SKIP_HI_RD;
        end else begin
          lo_next = lo + 1'b1;
          hi_next = hi - 1'b1;
          state_next = ST_SCAN_RD_LO;
        end
      end
      ST_SUMMARY: begin
        if (!out_full || !out_stall) begin
          out_load = 1'b1;
          res.is_summary       = 1'b1;
          res.found_any        = found;
          res.triplets_dropped = tdrop;
          res.inputs_dropped   = ovf;
          count_next = '0; ovf_next = 1'b0; found_next = 1'b0;
          tdrop_next = 1'b0; emitted_next = '0;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS)) else $error("count beyond capacity");
  a_emit_cap: assert property (@(posedge clk) disable iff (rst)
    emitted <= TW'(MAX_TRIPLETS)) else $error("too many triplets");
  a_summary_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUMMARY && out_load) |=> (count == '0 && emitted == '0))
    else $error("run state not cleared");
  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |-> state != ST_LOAD) else $error("result during load");
endmodule

[sv/tsz_store.sv]
// Value store: one write port, one registered read port.
module tsz_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rdata
);
  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/tsz_out.sv]
// Output register stage holding one result item.
module tsz_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tsz_pkg::result_t    din,
  output logic                full,
  input  logic                stall,
  output tsz_pkg::result_t    dout
);
  import tsz_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (!stall) begin
      full <= 1'b0;
    end
    if (load) dout <= din;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!full || !stall)) else $error("result overwritten");
endmodule
